// File: hdl/link_packet_deframer_macros.svh
// Assertion macros for the link packet deframer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LINK_PACKET_DEFRAMER_MACROS_SVH
`define LINK_PACKET_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define LPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link_packet_deframer: check failed");
// antecedent implies consequent in the next cycle
`define LPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link_packet_deframer: check failed");
`else
`define LPD_ASSERT_IMP(label, ante, cons)
`define LPD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hdl/lpd_pkg.sv
// Shared types and constants of the link packet deframer.
// No dependencies; used by every module of the block.
package lpd_pkg;

    // item kinds on the result channel
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_META    = 3'd1;
    localparam logic [2:0] KIND_RECORD  = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // bytes of the sequence and length fields that are kept
    localparam int SEQ_KEEP = 4;
    localparam int LEN_KEEP = 2;

    // result queue geometry (depth is a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ack_flag;
        logic [31:0] sequence_number;
        logic [7:0]  sender_id;
        logic [15:0] length_value;
        logic [7:0]  payload_byte;
        logic [5:0]  record_number;
        logic        record_end;
        logic        frame_error;
    } result_item_t;

    // results produced by the parser in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } lpd_push_t;

    // queue status seen by the input stage
    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] level;
    } lpd_queue_status_t;

endpackage

// File: hdl/lpd_parser.sv
// Packet parser: phase state and combinational decode of each byte item.
// Depends on lpd_pkg; drives up to two result items into the result queue.
module lpd_parser #(
    parameter int SEQ_BYTES   = 4,
    parameter int ID_BYTES    = 1,
    parameter int LEN_BYTES   = 2,
    parameter int MAX_RECORDS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lpd_pkg::byte_item_t  item,
    output lpd_pkg::lpd_push_t   push,
    output lpd_pkg::result_item_t res0,
    output lpd_pkg::result_item_t res1
);

    localparam int FIELD_MAX_SL = (SEQ_BYTES > LEN_BYTES) ? SEQ_BYTES : LEN_BYTES;
    localparam int FIELD_MAX    = (FIELD_MAX_SL > ID_BYTES) ? FIELD_MAX_SL : ID_BYTES;
    localparam int FBC_W        = $clog2(FIELD_MAX + 1);
    localparam int RC_W         = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {
        PH_ACK,
        PH_SEQ,
        PH_ID,
        PH_MLEN,
        PH_META,
        PH_RLEN,
        PH_RDATA,
        PH_DISCARD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [FBC_W-1:0]  fbc_reg, fbc_next;
    logic              ack_reg, ack_next;
    logic [31:0]       seq_reg, seq_next;
    logic [7:0]        sender_reg, sender_next;
    logic [15:0]       len_reg, len_next;
    logic [15:0]       rem_reg, rem_next;
    logic [RC_W-1:0]   rc_reg, rc_next;
    logic              err_reg, err_next;

    logic [FBC_W-1:0]  fbc_inc;
    logic [15:0]       len_base;
    logic [15:0]       len_added;
    logic [31:0]       seq_added;
    logic [15:0]       rem_dec;
    logic              item_valid;
    lpd_pkg::result_item_t byte_res;
    lpd_pkg::result_item_t end_res;
    logic              end_valid;
    logic              trunc;

    // byte lane accumulation for the multi-byte fields
    always_comb
    begin
        fbc_inc   = fbc_reg + 1'b1;
        rem_dec   = rem_reg - 1'b1;
        len_base  = (phase_reg == PH_RLEN && fbc_reg == '0) ? 16'd0 : len_reg;
        len_added = len_base;
        seq_added = seq_reg;
        for (int i = 0; i < lpd_pkg::LEN_KEEP; i++)
        begin
            if (i < LEN_BYTES && fbc_reg == FBC_W'(i))
                len_added[8*i +: 8] = len_base[8*i +: 8] | item.data_byte;
        end
        for (int i = 0; i < lpd_pkg::SEQ_KEEP; i++)
        begin
            if (i < SEQ_BYTES && fbc_reg == FBC_W'(i))
                seq_added[8*i +: 8] = seq_reg[8*i +: 8] | item.data_byte;
        end
    end

    // next state and result items
    always_comb
    begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        ack_next    = ack_reg;
        seq_next    = seq_reg;
        sender_next = sender_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        rc_next     = rc_reg;
        err_next    = err_reg;
        item_valid  = 1'b0;
        byte_res    = '0;
        end_res     = '0;
        end_valid   = 1'b0;
        trunc       = 1'b1;

        if (fire)
        begin
            case (phase_reg)
                PH_ACK:
                begin
                    ack_next   = (item.data_byte != 8'd0);
                    fbc_next   = '0;
                    phase_next = PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_next = seq_added;
                    fbc_next = fbc_inc;
                    if (fbc_inc >= FBC_W'(SEQ_BYTES))
                    begin
                        fbc_next   = '0;
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    if (fbc_reg == '0)
                        sender_next = item.data_byte;
                    fbc_next = fbc_inc;
                    if (fbc_inc >= FBC_W'(ID_BYTES))
                    begin
                        fbc_next   = '0;
                        len_next   = 16'd0;
                        phase_next = PH_MLEN;
                    end
                end
                PH_MLEN:
                begin
                    len_next = len_added;
                    fbc_next = fbc_inc;
                    if (fbc_inc >= FBC_W'(LEN_BYTES))
                    begin
                        fbc_next                 = '0;
                        item_valid               = 1'b1;
                        byte_res.kind            = lpd_pkg::KIND_HEADER;
                        byte_res.ack_flag        = ack_reg;
                        byte_res.sequence_number = seq_reg;
                        byte_res.sender_id       = sender_reg;
                        byte_res.length_value    = len_added;
                        rem_next                 = len_added;
                        phase_next = (len_added != 16'd0) ? PH_META : PH_RLEN;
                    end
                end
                PH_META:
                begin
                    rem_next              = rem_dec;
                    item_valid            = 1'b1;
                    byte_res.kind         = lpd_pkg::KIND_META;
                    byte_res.payload_byte = item.data_byte;
                    byte_res.record_end   = (rem_dec == 16'd0);
                    if (rem_dec == 16'd0)
                        phase_next = PH_RLEN;
                end
                PH_RLEN:
                begin
                    // record limit is checked when a new length begins
                    if (fbc_reg == '0 && rc_reg >= RC_W'(MAX_RECORDS))
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        len_next = len_added;
                        fbc_next = fbc_inc;
                        if (fbc_inc >= FBC_W'(LEN_BYTES))
                        begin
                            fbc_next = '0;
                            rc_next  = rc_reg + 1'b1;
                            if (len_added == 16'd0)
                            begin
                                item_valid             = 1'b1;
                                byte_res.kind          = lpd_pkg::KIND_EMPTY;
                                byte_res.record_number = 6'(rc_reg);
                                byte_res.record_end    = 1'b1;
                            end
                            else
                            begin
                                rem_next   = len_added;
                                phase_next = PH_RDATA;
                            end
                        end
                    end
                end
                PH_RDATA:
                begin
                    rem_next               = rem_dec;
                    item_valid             = 1'b1;
                    byte_res.kind          = lpd_pkg::KIND_RECORD;
                    byte_res.payload_byte  = item.data_byte;
                    byte_res.record_number = 6'(rc_reg - 1'b1);
                    byte_res.record_end    = (rem_dec == 16'd0);
                    if (rem_dec == 16'd0)
                        phase_next = PH_RLEN;
                end
                default:
                begin
                    // discard until the datagram ends
                end
            endcase

            // end of datagram: report and return to the reset state
            if (item.last_byte)
            begin
                if (phase_next == PH_DISCARD)
                    trunc = 1'b0;
                else if (phase_next == PH_RLEN)
                    trunc = (fbc_next != '0);
                else
                    trunc = 1'b1;
                end_valid               = 1'b1;
                end_res.kind            = lpd_pkg::KIND_END;
                end_res.ack_flag        = ack_next;
                end_res.sequence_number = seq_next;
                end_res.sender_id       = sender_next;
                end_res.length_value    = 16'(rc_next);
                end_res.frame_error     = trunc | err_next;
                phase_next  = PH_ACK;
                fbc_next    = '0;
                ack_next    = 1'b0;
                seq_next    = 32'd0;
                sender_next = 8'd0;
                len_next    = 16'd0;
                rem_next    = 16'd0;
                rc_next     = '0;
                err_next    = 1'b0;
            end
        end
    end

    // compact the byte item and the end item into the two push slots
    always_comb
    begin
        push.first  = item_valid | end_valid;
        push.second = item_valid & end_valid;
        res0        = item_valid ? byte_res : end_res;
        res1        = end_res;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ACK;
            fbc_reg    <= '0;
            ack_reg    <= 1'b0;
            seq_reg    <= 32'd0;
            sender_reg <= 8'd0;
            len_reg    <= 16'd0;
            rem_reg    <= 16'd0;
            rc_reg     <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            ack_reg    <= ack_next;
            seq_reg    <= seq_next;
            sender_reg <= sender_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            rc_reg     <= rc_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: hdl/lpd_result_queue.sv
// Result queue: small register queue taking up to two items a cycle.
// Depends on lpd_pkg; its head drives the result channel directly.
module lpd_result_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpd_pkg::lpd_push_t        push,
    input  lpd_pkg::result_item_t     res0,
    input  lpd_pkg::result_item_t     res1,
    output logic                      result_valid,
    input  logic                      result_ready,
    output lpd_pkg::result_item_t     result_data,
    output lpd_pkg::lpd_queue_status_t status
);

    lpd_pkg::result_item_t entry_reg [lpd_pkg::QUEUE_DEPTH];

    logic [lpd_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [lpd_pkg::QPTR_W-1:0] tail_reg, tail_next;
    logic [lpd_pkg::QCNT_W-1:0] level_reg, level_next;
    logic [lpd_pkg::QPTR_W-1:0] tail_plus1;
    logic                       pop;

    // pointer and fill level update; pointers wrap at the power-of-two depth
    always_comb
    begin
        pop        = result_valid & result_ready;
        tail_plus1 = tail_reg + 1'b1;
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + lpd_pkg::QPTR_W'(push.first) + lpd_pkg::QPTR_W'(push.second);
        level_next = level_reg + lpd_pkg::QCNT_W'(push.first)
                   + lpd_pkg::QCNT_W'(push.second) - lpd_pkg::QCNT_W'(pop);
    end

    assign result_valid = (level_reg != '0);
    assign result_data  = entry_reg[head_reg];
    assign status.room  = (level_reg <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH - 2));
    assign status.level = level_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push.first)
            entry_reg[tail_reg] <= res0;
        if (push.second)
            entry_reg[tail_plus1] <= res1;
    end

endmodule

// File: hdl/link_packet_deframer.sv
// Byte-serial datagram deframer: parses ack flag, sequence number, sender id,
// metadata and length-prefixed records into tagged result items.
//
// byte channel: byte_valid/byte_ready with byte_data, one datagram byte per
//   item and last_byte set on the final byte of each datagram.
// result channel: result_valid/result_ready with result_data. A header item
//   follows the metadata length, then one item per metadata or record byte,
//   an empty-record item for each zero-length record, and an end item with
//   the record count and frame_error on the final byte.
// Path: an accepted byte waits in the input register and is parsed from it
//   once the queue has room; its results are queued and offered from there.
// Throughput: one byte per cycle while the queue has room. The final byte of a
//   datagram yields two items; the four-entry result queue absorbs them and the
//   input accepts whenever at least two entries are free.
// Reset clears the parse state, the input register and the result queue;
//   the first byte after reset is taken as an ack flag byte.
// When the receiver stalls, the queue fills and byte_ready drops once the
//   input register holds an item that cannot be parsed.
// Depends on lpd_pkg, lpd_parser, lpd_result_queue and the macros header.
`include "link_packet_deframer_macros.svh"

module link_packet_deframer #(
    parameter int SEQ_BYTES   = 4,
    parameter int ID_BYTES    = 1,
    parameter int LEN_BYTES   = 2,
    parameter int MAX_RECORDS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  lpd_pkg::byte_item_t   byte_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lpd_pkg::result_item_t result_data
);

    logic                       byte_valid_reg, byte_valid_next;
    lpd_pkg::byte_item_t        byte_item_reg;
    logic                       fire;
    lpd_pkg::lpd_push_t         push;
    lpd_pkg::result_item_t      res0;
    lpd_pkg::result_item_t      res1;
    lpd_pkg::lpd_queue_status_t status;

    // input register advances when the queue has room for two items
    assign fire       = byte_valid_reg & status.room;
    assign byte_ready = ~byte_valid_reg | fire;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (byte_ready)
            byte_valid_next = byte_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else
            byte_valid_reg <= byte_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid & byte_ready)
            byte_item_reg <= byte_data;
    end

    // parser
    lpd_parser #(
        .SEQ_BYTES   (SEQ_BYTES),
        .ID_BYTES    (ID_BYTES),
        .LEN_BYTES   (LEN_BYTES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (byte_item_reg),
        .push  (push),
        .res0  (res0),
        .res1  (res1)
    );

    // result queue
    lpd_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .res0         (res0),
        .res1         (res1),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .status       (status)
    );

    // checks
    `LPD_ASSERT_IMP(a_level_in_range, 1'b1, status.level <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH))
    `LPD_ASSERT_NXT(a_input_holds, byte_valid_reg && !fire, byte_valid_reg && $stable(byte_item_reg))
    `LPD_ASSERT_IMP(a_second_needs_first, push.second, push.first && res1.kind == lpd_pkg::KIND_END)
    `LPD_ASSERT_IMP(a_end_clean,
        result_valid && result_data.kind == lpd_pkg::KIND_END,
        result_data.payload_byte == 8'd0 && result_data.record_number == 6'd0)

endmodule
